/* rtl/urlpd_pkg.sv */
package urlpd_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 16;
  localparam int MAX_RES = 3;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // Escape tracking
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  // Input beat
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               out_last;
    logic [TOTAL_W-1:0] invalid_total;
    logic               was_changed;
  } out_item_t;

  // Results caused by one input beat, handed from front to back
  typedef struct packed {
    logic [1:0]                    cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic                          last;
    logic [TOTAL_W-1:0]            total;
    logic                          changed;
  } bundle_t;

endpackage

/* rtl/urlpd_front.sv */
module urlpd_front
  import urlpd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     accept,
  input  in_item_t item,
  output logic     bnd_push,
  output bundle_t  bnd
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                  phase_r, phase_nxt;
  logic [BYTE_W-1:0]       first_r, first_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                    chg_r, chg_nxt;
  logic                    plus_r;

  logic [BYTE_W-1:0]       b;
  logic                    last;
  logic [4:0]              hx_b, hx_f;
  logic [1:0]              pre_n;
  logic [BYTE_W-1:0]       pre0, pre1;
  logic                    pl_emit;
  logic [BYTE_W-1:0]       pl_byte;
  logic                    inc_a, inc_b;
  logic                    chg_step;
  logic [COUNT_BITS-1:0]   cnt_a, cnt_b;
  logic [TOTAL_W-1:0]      total;

  // Decode one hex digit: {valid, value}
  function automatic logic [4:0] hexval(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  assign b    = item.in_byte;
  assign last = item.in_last;
  assign hx_b = hexval(b);
  assign hx_f = hexval(first_r);

  // Classify the beat against the held escape
  always_comb begin
    phase_nxt = PH_IDLE;
    first_nxt = first_r;
    pre_n     = 2'd0;
    pre0      = CH_PCT;
    pre1      = first_r;
    inc_a     = 1'b0;
    chg_step  = 1'b0;
    pl_emit   = 1'b0;
    pl_byte   = b;
    inc_b     = 1'b0;
    case (phase_r)
      PH_PCT: begin
        if (hx_b[4] && !last) begin
          first_nxt = b;
          phase_nxt = PH_HEX;
        end else begin
          inc_a   = 1'b1;
          pre_n   = 2'd1;
          pl_emit = 1'b1;
        end
      end
      PH_HEX: begin
        if (hx_b[4]) begin
          pre_n    = 2'd1;
          pre0     = {hx_f[3:0], hx_b[3:0]};
          chg_step = 1'b1;
        end else begin
          inc_a   = 1'b1;
          pre_n   = 2'd2;
          pl_emit = 1'b1;
        end
      end
      default: begin
        pl_emit = 1'b1;
      end
    endcase
    // Handle the byte itself with nothing held
    if (pl_emit) begin
      if (b == CH_PCT) begin
        if (last) begin
          inc_b = 1'b1;
        end else begin
          pl_emit   = 1'b0;
          phase_nxt = PH_PCT;
        end
      end else if (b == CH_PLUS && plus_r) begin
        chg_step = 1'b1;
        pl_byte  = CH_SPACE;
      end
    end
  end

  // Count invalid escapes, saturating
  always_comb begin
    cnt_a = (inc_a && cnt_r != CNT_MAX) ? cnt_r + COUNT_BITS'(1) : cnt_r;
    cnt_b = (inc_b && cnt_a != CNT_MAX) ? cnt_a + COUNT_BITS'(1) : cnt_a;
  end

  // Limit the reported count to the field width
  generate
    if (COUNT_BITS <= TOTAL_W) begin : g_narrow
      assign total = TOTAL_W'(cnt_b);
    end else begin : g_wide
      assign total = (|cnt_b[COUNT_BITS-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : cnt_b[TOTAL_W-1:0];
    end
  endgenerate

  // Pack the results of this beat
  always_comb begin
    bnd.cnt      = pre_n + {1'b0, pl_emit};
    bnd.bytes[0] = (pre_n != 2'd0) ? pre0 : pl_byte;
    bnd.bytes[1] = (pre_n == 2'd2) ? pre1 : pl_byte;
    bnd.bytes[2] = pl_byte;
    bnd.last     = last;
    bnd.total    = total;
    bnd.changed  = chg_r | chg_step;
    bnd_push     = accept && (bnd.cnt != 2'd0);
  end

  // Advance string state; clear it at the end of a string
  always_comb begin
    cnt_nxt = cnt_b;
    chg_nxt = chg_r | chg_step;
    if (last) begin
      cnt_nxt   = '0;
      chg_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= '0;
      cnt_r   <= '0;
      chg_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= last ? PH_IDLE : phase_nxt;
      first_r <= last ? '0 : first_nxt;
      cnt_r   <= cnt_nxt;
      chg_r   <= chg_nxt;
    end
  end

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r <= 1'b1;
    end else if (cfg_we) begin
      plus_r <= cfg_data;
    end
  end

endmodule

/* rtl/urlpd_queue.sv */
module urlpd_queue
  import urlpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd,
  output logic    empty,
  output bundle_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Store a beat
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* rtl/urlpd_back.sv */
module urlpd_back
  import urlpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  bundle_t   q_head,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  out_item_t  out_r, out_nxt;
  logic       load;
  logic       end_of_bnd;

  assign load       = !q_empty && (!valid_r || pop);
  assign end_of_bnd = (idx_r == q_head.cnt - 2'd1);

  // Pick the next result out of the head bundle
  always_comb begin
    q_rd      = load && end_of_bnd;
    idx_nxt   = idx_r;
    out_nxt   = out_r;
    valid_nxt = valid_r && !pop;
    if (load) begin
      valid_nxt              = 1'b1;
      out_nxt.out_byte       = q_head.bytes[idx_r];
      out_nxt.out_last       = 1'b0;
      out_nxt.invalid_total  = '0;
      out_nxt.was_changed    = 1'b0;
      idx_nxt                = idx_r + 2'd1;
      if (end_of_bnd) begin
        idx_nxt = 2'd0;
        if (q_head.last) begin
          out_nxt.out_last      = 1'b1;
          out_nxt.invalid_total = q_head.total;
          out_nxt.was_changed   = q_head.changed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = !valid_r;
  assign out_item = out_r;

endmodule

/* rtl/url_percent_decoder.sv */
// Streaming URL percent-decoder. Push one encoded byte per beat with in_last on the final
// byte of a string; decoded bytes come out in order with out_last on the final one, which
// also carries the saturating count of undecodable '%' signs and whether anything was
// converted. A '%' with a held hex digit that fails to complete releases up to three
// results from one input beat. The block accepts one byte per cycle while full is low
// and delivers one result per cycle while a result is waiting and pop is high; the output
// register delivers a single result per cycle, so a beat with two or three results holds
// it longer, and the QUEUE_DEPTH-entry queue between the classifier and output absorbs
// the difference before full rises. Results pass the queue and then the output register.
// cfg_data sets plus-to-space mode (reset 1); write it only while the block is idle.
module url_percent_decoder
  import urlpd_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  logic    accept;
  logic    bnd_push;
  bundle_t bnd;
  logic    q_full, q_empty, q_rd;
  bundle_t q_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify input beats
  urlpd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .bnd_push (bnd_push),
    .bnd      (bnd)
  );

  // Decouple front and back
  urlpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (bnd_push),
    .wr_data (bnd),
    .full    (q_full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  // Serialize results
  urlpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
